FILE: rtl/core/wdt_pkg.sv
// shared types and constants for the word and period tokenizer
`timescale 1ns / 1ps
`default_nettype none

package wdt_pkg;

  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLoA   = 8'h61;
  localparam logic [7:0] CharLoZ   = 8'h7A;

  typedef enum logic [1:0] {
    KIND_WORD  = 2'd0,
    KIND_CWORD = 2'd1,
    KIND_DOT   = 2'd2,
    KIND_ERROR = 2'd3
  } token_kind_e;

  typedef enum logic [2:0] {
    S_RUN,
    S_RD,
    S_EMIT,
    S_DOT,
    S_ERR,
    S_HALT
  } state_e;

  typedef struct packed {
    logic store_letter;
    logic latch_char;
    logic rd_issue;
    logic rd_next;
    logic clear_word;
    logic emit_word;
    logic word_final;
    logic emit_dot;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    logic in_eos;
    logic in_letter;
    logic in_space;
    logic in_dot;
    logic word_empty;
    logic rd_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/wdt_ctrl.sv
// controller state machine for the tokenizer
`timescale 1ns / 1ps
`default_nettype none

module wdt_ctrl
  import wdt_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   dot_after_q, dot_after_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      dot_after_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dot_after_q <= dot_after_d;
    end
  end

  assign in_ready_o = (state_q == S_RUN) || (state_q == S_HALT);
  assign accept     = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d     = state_q;
    dot_after_d = dot_after_q;
    unique case (state_q)
      S_RUN: begin
        if (accept) begin
          priority if (status_i.in_eos) begin
            state_d = S_HALT;
          end else if (status_i.in_letter) begin
            state_d = S_RUN;
          end else if (status_i.in_space) begin
            if (!status_i.word_empty) begin
              state_d     = S_RD;
              dot_after_d = 1'b0;
            end
          end else if (status_i.in_dot) begin
            if (status_i.word_empty) begin
              state_d = S_DOT;
            end else begin
              state_d     = S_RD;
              dot_after_d = 1'b1;
            end
          end else begin
            state_d = S_ERR;
          end
        end
      end
      S_RD: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          if (status_i.rd_last) begin
            state_d = dot_after_q ? S_DOT : S_RUN;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_DOT: begin
        if (status_i.out_free) begin
          state_d = S_RUN;
        end
      end
      S_ERR: begin
        if (status_i.out_free) begin
          state_d = S_HALT;
        end
      end
      S_HALT: begin
        state_d = S_HALT;
      end
      default: begin
        state_d = S_HALT;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_RUN: begin
        if (accept && !status_i.in_eos) begin
          cmd_o.store_letter = status_i.in_letter;
          cmd_o.latch_char   = !status_i.in_letter && !status_i.in_space &&
                               !status_i.in_dot;
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_word  = 1'b1;
          cmd_o.word_final = !dot_after_q;
          cmd_o.clear_word = status_i.rd_last;
          cmd_o.rd_next    = !status_i.rd_last;
        end
      end
      S_DOT: begin
        cmd_o.emit_dot = status_i.out_free;
      end
      S_ERR: begin
        cmd_o.emit_err = status_i.out_free;
      end
      S_HALT: begin
        cmd_o = '0;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/wdt_datapath.sv
// word buffer, character classifier and output register
`timescale 1ns / 1ps
`default_nettype none

module wdt_datapath
  import wdt_pkg::*;
#(
  parameter int unsigned MAX_WORD_LEN = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] in_char_i,
  input  wire logic       in_eos_i,
  input  wire cmd_t       cmd_i,
  output status_t         status_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            out_end_o,
  output logic [3:0]      out_user_o
);

  localparam int unsigned LW = $clog2(MAX_WORD_LEN + 1);
  localparam int unsigned IW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam logic [LW-1:0] MaxLen = LW'(MAX_WORD_LEN);

  logic [7:0]    mem_q [MAX_WORD_LEN];
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] rd_idx_q, rd_idx_d;
  logic          cap_q, cap_d;
  logic          ovf_q, ovf_d;
  logic [7:0]    rd_data_q;
  logic [7:0]    err_char_q;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_char_q;
  logic          out_end_q;
  token_kind_e   out_kind_q;
  logic          out_trunc_q;
  logic          out_last_q;
  logic          is_upper;
  logic          is_lower;
  logic          room;
  logic          out_load;

  assign is_upper = (in_char_i >= CharUpA) && (in_char_i <= CharUpZ);
  assign is_lower = (in_char_i >= CharLoA) && (in_char_i <= CharLoZ);
  assign room     = (len_q < MaxLen);
  assign out_load = cmd_i.emit_word || cmd_i.emit_dot || cmd_i.emit_err;

  assign status_o.in_eos     = in_eos_i;
  assign status_o.in_letter  = is_upper || is_lower;
  assign status_o.in_space   = (in_char_i == CharSpace) || (in_char_i == CharTab) ||
                               (in_char_i == CharNl);
  assign status_o.in_dot     = (in_char_i == CharDot);
  assign status_o.word_empty = (len_q == '0);
  assign status_o.rd_last    = ((rd_idx_q + LW'(1)) == len_q);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // word buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_letter && room) begin
      mem_q[len_q[IW-1:0]] <= in_char_i;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem_q[rd_idx_q[IW-1:0]];
    end
  end

  always_comb begin
    len_d    = len_q;
    cap_d    = cap_q;
    ovf_d    = ovf_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.store_letter) begin
      if ((len_q == '0) && is_upper) begin
        cap_d = 1'b1;
      end
      if (room) begin
        len_d = len_q + LW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.rd_next) begin
      rd_idx_d = rd_idx_q + LW'(1);
    end
    if (cmd_i.clear_word) begin
      len_d    = '0;
      cap_d    = 1'b0;
      ovf_d    = 1'b0;
      rd_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      cap_q    <= 1'b0;
      ovf_q    <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      len_q    <= len_d;
      cap_q    <= cap_d;
      ovf_q    <= ovf_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_char) begin
      err_char_q <= in_char_i;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      priority if (cmd_i.emit_word) begin
        out_kind_q  <= cap_q ? KIND_CWORD : KIND_WORD;
        out_char_q  <= rd_data_q;
        out_end_q   <= status_o.rd_last;
        out_trunc_q <= ovf_q;
        out_last_q  <= status_o.rd_last && cmd_i.word_final;
      end else if (cmd_i.emit_dot) begin
        out_kind_q  <= KIND_DOT;
        out_char_q  <= CharDot;
        out_end_q   <= 1'b1;
        out_trunc_q <= 1'b0;
        out_last_q  <= 1'b1;
      end else begin
        out_kind_q  <= KIND_ERROR;
        out_char_q  <= err_char_q;
        out_end_q   <= 1'b1;
        out_trunc_q <= 1'b0;
        out_last_q  <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_end_o   = out_end_q;
  assign out_user_o  = {out_last_q, out_trunc_q, out_kind_q};

endmodule

`default_nettype wire

FILE: rtl/core/word_dot_tokenizer.sv
// top level of the character stream word and period tokenizer
//
//   channel  dir  tdata           tlast          tuser
//   s_axis   in   char_code[7:0]  end_of_stream  -
//   m_axis   out  token_char[7:0] token_end      kind[1:0] truncated[2] last_result[3]
//
// a letter, a blank with no pending word and an end of stream are taken in the run state alone
// a word end replays the buffer, each stored letter through a read state and an emit state
// for the registered read of the word memory, then a dot state for a trailing dot
// an error or a dot alone passes to its own state, which emits once the output register is free
// reset is asynchronous and active low; the word memory needs no clearing
// a stalled output holds the replay; input is taken while a result waits
`timescale 1ns / 1ps
`default_nettype none

module word_dot_tokenizer
  import wdt_pkg::*;
#(
  parameter int unsigned MAX_WORD_LEN = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // char_code[7:0]
  input  wire logic       s_axis_tlast_i,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // token_char[7:0]
  output logic            m_axis_tlast_o,
  output logic [3:0]      m_axis_tuser_o    // token_kind[1:0], word_truncated, last_result
);

  cmd_t    cmd;
  status_t status;

  wdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wdt_datapath #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_char_i   (s_axis_tdata_i),
    .in_eos_i    (s_axis_tlast_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (m_axis_tdata_o),
    .out_end_o   (m_axis_tlast_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/wdt_checker.sv
// port level checks for the tokenizer and their bind
`timescale 1ns / 1ps
`default_nettype none

module wdt_checker
  import wdt_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic       m_axis_tlast_o,
  input wire logic [3:0] m_axis_tuser_o
);

  logic is_dot;
  logic is_err;

  assign is_dot = (m_axis_tuser_o[1:0] == KIND_DOT);
  assign is_err = (m_axis_tuser_o[1:0] == KIND_ERROR);

  // stalled transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled output changed");

  // nothing follows an error
  a_err_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && is_err |=> !m_axis_tvalid_o)
    else $error("output after error token");

  // dot and error are single, final and never truncated
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (is_dot || is_err) |->
      m_axis_tlast_o && !m_axis_tuser_o[2] && m_axis_tuser_o[3])
    else $error("bad dot or error framing");

  // final result of an input closes its token
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[3] |-> m_axis_tlast_o)
    else $error("last result without token end");

  a_dot_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && is_dot |-> (m_axis_tdata_o == CharDot))
    else $error("dot token with wrong character");

endmodule

bind word_dot_tokenizer wdt_checker u_wdt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

FILE: tb/tb_word_dot_tokenizer.sv
// testbench for the word and period tokenizer with directed, overflow, random, stall and halt tests
`timescale 1ns / 1ps

module tb_word_dot_tokenizer;
  import wdt_pkg::*;

  localparam int unsigned WordCap = 16;
  localparam int unsigned RxHoldCycles = 300;
  localparam int unsigned StallLimit = 3000;
  localparam int MaxReports = 10;
  localparam logic [7:0] CharBang = 8'h21;

  typedef enum logic [1:0] {
    PH_RUN,
    PH_EOS,
    PH_ERR
  } run_phase_e;

  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  ch;
    logic        tok_end;
    logic        trunc;
    logic        last;
  } token_t;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = '0;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [3:0] m_tuser;

  // predictor state
  token_t      token_fifo[$];
  run_phase_e  phase    = PH_RUN;
  logic [7:0]  letters[WordCap];
  int unsigned word_len = 0;
  logic        cap_flag = 1'b0;
  logic        ovf_flag = 1'b0;

  int          tx_idle_pct  = 0;
  int          rx_idle_pct  = 0;
  int unsigned hold_seq     = 0;
  int unsigned hold_ack     = 0;
  int unsigned hold_left    = 0;
  int unsigned stall_cnt    = 0;
  int          mismatch_cnt = 0;

  word_dot_tokenizer #(
    .MAX_WORD_LEN(WordCap)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast),
    .m_axis_tuser_o (m_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void push_token(input token_kind_e kind, input logic [7:0] ch,
                                     input logic tok_end, input logic trunc, input logic last);
    token_t tk;
    tk.kind    = kind;
    tk.ch      = ch;
    tk.tok_end = tok_end;
    tk.trunc   = trunc;
    tk.last    = last;
    token_fifo.push_back(tk);
  endfunction

  function automatic void emit_word(input logic final_here);
    token_kind_e kind;
    kind = cap_flag ? KIND_CWORD : KIND_WORD;
    for (int unsigned i = 0; i < word_len; i++) begin
      push_token(kind, letters[i], i + 1 == word_len, ovf_flag,
                 (i + 1 == word_len) && final_here);
    end
    word_len = 0;
    cap_flag = 1'b0;
    ovf_flag = 1'b0;
  endfunction

  function automatic void tokenize_char(input logic [7:0] ch, input logic eos);
    logic is_upper;
    logic is_lower;
    is_upper = (ch >= CharUpA) && (ch <= CharUpZ);
    is_lower = (ch >= CharLoA) && (ch <= CharLoZ);
    if (phase != PH_RUN) begin
      // halted, nothing changes
    end else if (eos) begin
      phase = PH_EOS;
    end else if (is_upper || is_lower) begin
      if (word_len == 0 && is_upper) cap_flag = 1'b1;
      if (word_len < WordCap) begin
        letters[word_len] = ch;
        word_len++;
      end else begin
        ovf_flag = 1'b1;
      end
    end else if (ch == CharSpace || ch == CharTab || ch == CharNl) begin
      emit_word(1'b1);
    end else if (ch == CharDot) begin
      emit_word(1'b0);
      push_token(KIND_DOT, CharDot, 1'b1, 1'b0, 1'b1);
    end else begin
      push_token(KIND_ERROR, ch, 1'b1, 1'b0, 1'b1);
      phase = PH_ERR;
    end
  endfunction

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) ? CharUpA : CharLoA) + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_sep();
    case ($urandom_range(3))
      0: return CharSpace;
      1: return CharTab;
      2: return CharNl;
      default: return CharDot;
    endcase
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic eos = 1'b0);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= eos;
    do @(posedge clk_i); while (!s_tready);
    tokenize_char(ch, eos);
  endtask

  task automatic send_word(input string w);
    for (int i = 0; i < w.len(); i++) send_char(w[i]);
  endtask

  task automatic drain_tokens();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (token_fifo.size() != 0);
  endtask

  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_char(CharSpace);
    send_char(CharDot);
    send_word("Zy");
    send_char(CharTab);
    send_word("Ab");
    send_char(CharDot);
    send_word("cD");
    send_char(CharNl);
    send_word("a");
    send_char(CharSpace);
    drain_tokens();
  endtask

  task automatic test_overflow();
    send_word("Qazwsxedcrfvtgbyhnz");
    send_char(CharDot);
    send_word("mz");
    send_char(CharSpace);
    drain_tokens();
  endtask

  task automatic test_random(input int tx_pct, input int rx_pct, input int n_items);
    int sent;
    int len;
    int pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        pick = $urandom_range(99);
        if (pick < 80) len = $urandom_range(1, 8);
        else if (pick < 95) len = $urandom_range(9, 16);
        else len = $urandom_range(17, 24);
        for (int i = 0; i < len; i++) send_char(rand_letter());
        send_char(rand_sep());
        sent += len + 1;
      end else begin
        // runs of separators with no word in front
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) send_char(rand_sep());
        sent += len;
      end
    end
    drain_tokens();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_seq <= hold_seq + 1;
    repeat (5) begin
      for (int i = 0; i < WordCap; i++) send_char(rand_letter());
      send_char(CharDot);
    end
    drain_tokens();
  endtask

  task automatic test_halt();
    logic [7:0] bad;
    tx_idle_pct = 16;
    rx_idle_pct = 16;
    // pick a byte that is neither letter, blank nor period
    do begin
      bad = $urandom_range(1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 127));
    end while ((bad >= CharUpA && bad <= CharUpZ) || (bad >= CharLoA && bad <= CharLoZ) ||
               bad == CharSpace || bad == CharTab || bad == CharNl || bad == CharDot);
    send_word("Ab");
    send_char(bad);
    // halted: all of these are swallowed
    send_char(8'hFF, 1'b1);
    send_char(CharBang);
    send_word("xY");
    send_char(CharSpace);
    send_char(CharDot);
    repeat (8) send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
    drain_tokens();
  endtask

  // result side: ready pattern, long hold on request, and checking
  always @(posedge clk_i) begin : rx_side
    token_t got;
    token_t want;
    if (m_tvalid && m_tready) begin
      got.kind    = token_kind_e'(m_tuser[1:0]);
      got.ch      = m_tdata;
      got.tok_end = m_tlast;
      got.trunc   = m_tuser[2];
      got.last    = m_tuser[3];
      if (token_fifo.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports)
          $display("unexpected token: kind %0d char %h end %b trunc %b last %b",
                   got.kind, got.ch, got.tok_end, got.trunc, got.last);
      end else begin
        want = token_fifo.pop_front();
        if (got != want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports)
            $display({"token mismatch: exp kind %0d char %h end %b trunc %b last %b,",
                      " got kind %0d char %h end %b trunc %b last %b"},
                     want.kind, want.ch, want.tok_end, want.trunc, want.last,
                     got.kind, got.ch, got.tok_end, got.trunc, got.last);
        end
      end
    end
    if (hold_seq != hold_ack) begin
      hold_ack  <= hold_seq;
      hold_left <= RxHoldCycles;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("tb_word_dot_tokenizer NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random(16, 68, 100);
    test_random(68, 16, 100);
    test_random(0, 0, 100);
    test_backpressure();
    test_halt();
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0 && token_fifo.size() == 0) begin
      $display("tb_word_dot_tokenizer OK");
    end else begin
      $display("tb_word_dot_tokenizer NOT OK");
    end
    $finish;
  end

endmodule
